// File: hw/rtl/rs_pkg.sv
package rs_pkg;

	localparam int MaxTaps  = 64;
	localparam int MaxTrace = 4096;

	localparam int TcW   = 7;
	localparam int TapW  = 16;
	localparam int RefW  = 16;
	localparam int ZW    = 32;
	localparam int ValW  = 40;
	localparam int PosW  = 12;
	localparam int AccW  = 48;

	localparam logic OP_TAP    = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// input transaction payload
	typedef struct packed {
		logic                   operation;
		logic [5:0]             tap_index;
		logic signed [TapW-1:0] tap_value;
		logic [15:0]            density;
		logic [15:0]            interval_time;
		logic                   last_sample;
	} in_item_t;

	// result transaction payload
	typedef struct packed {
		logic signed [ValW-1:0] trace_value;
		logic [PosW-1:0]        trace_position;
		logic                   last_output;
	} out_item_t;

	// front to back command
	typedef struct packed {
		logic                   is_tap;
		logic [5:0]             tap_index;
		logic signed [TapW-1:0] tap_value;
		logic                   start;
		logic                   push;
		logic signed [RefW-1:0] refl;
		logic                   last;
		logic [TcW-1:0]         taps;
	} cmd_t;

	typedef enum logic [2:0] {
		FE_IDLE,
		FE_DIV,
		FE_SEND,
		FE_WAIT
	} fe_state_t;

	typedef enum logic [2:0] {
		BE_IDLE,
		BE_SHIFT,
		BE_MAC,
		BE_EMIT,
		BE_FLUSH
	} be_state_t;

endpackage

// File: hw/rtl/rs_if.sv
interface rs_in_if;
	logic              valid;
	logic              ready;
	rs_pkg::in_item_t  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rs_out_if;
	logic              valid;
	logic              ready;
	rs_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rs_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [rs_pkg::TcW-1:0]     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/reflectivity_seismogram.sv
// channel | role   | payload
// in_ch   | sink   | operation, tap fields, density, interval_time, last_sample
// out_ch  | source | trace_value, trace_position, last_output
// cfg_ch  | sink   | tap_count (7 bits)
// front end: a tap load or a trace's first sample is accepted and then sent; any other
// sample also runs the 48-step restoring divider and a wait step before the send; back end
// per output: shift, multiply-accumulate over the taps, emit, then an idle or flush step.
// the queue overlaps both ends, so the slower one sets the rate;
// the last sample adds centre + 1 zero shifts.
// arst_n clears control state; taps are undefined until loaded. a stalled result holds
// the back end, then the queue fills and the input stalls.
module reflectivity_seismogram #(
	parameter int MAX_TAPS  = rs_pkg::MaxTaps,
	parameter int MAX_TRACE = rs_pkg::MaxTrace
) (
	input logic  clk,
	input logic  arst_n,
	rs_in_if.sink     in_ch,
	rs_out_if.source  out_ch,
	rs_cfg_if.sink    cfg_ch
);
	logic [rs_pkg::TcW-1:0] tap_count_q;
	rs_pkg::cmd_t f_cmd, b_cmd;
	logic f_v, f_r, b_v, b_r;

	assign cfg_ch.ready = 1'b1;

	// tap count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tap_count_q <= rs_pkg::TcW'(64);
		else if (cfg_ch.valid) tap_count_q <= cfg_ch.data;
	end

	rs_front #(.MAX_TRACE(MAX_TRACE)) u_front (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
		.tap_count(tap_count_q),
		.cmd_valid(f_v), .cmd_ready(f_r), .cmd(f_cmd)
	);

	rs_fifo u_fifo (
		.clk, .arst_n,
		.wr_valid(f_v), .wr_ready(f_r), .wr_data(f_cmd),
		.rd_valid(b_v), .rd_ready(b_r), .rd_data(b_cmd)
	);

	rs_back #(.MAX_TAPS(MAX_TAPS), .MAX_TRACE(MAX_TRACE)) u_back (
		.clk, .arst_n,
		.cmd_valid(b_v), .cmd_ready(b_r), .cmd(b_cmd),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
	);

`ifndef SYNTH
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
		else $error("result dropped under stall");
	a_q_flow: assert property (@(posedge clk) disable iff (!arst_n)
		f_v && !f_r |=> f_v)
		else $error("front lost queued command");
`endif
endmodule

// File: hw/rtl/rs_front.sv
module rs_front #(
	parameter int MAX_TRACE = rs_pkg::MaxTrace
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  rs_pkg::in_item_t       in_data,
	input  logic [rs_pkg::TcW-1:0] tap_count,
	output logic                   cmd_valid,
	input  logic                   cmd_ready,
	output rs_pkg::cmd_t           cmd
);
	localparam int SW = $clog2(MAX_TRACE);

	rs_pkg::fe_state_t state_q, state_d;
	logic [rs_pkg::ZW-1:0] prev_z_q;
	logic [SW-1:0]         seen_q;
	rs_pkg::cmd_t          cmd_q;
	// restoring divider: numerator diff<<15 (48b), denominator sum (33b)
	logic [47:0]           num_q;
	logic [32:0]           den_q;
	logic [33:0]           rem_q;
	logic [47:0]           quo_q;
	logic [5:0]            cnt_q;
	logic                  neg_q;
	logic [33:0]           rem_sh;
	logic [34:0]           rem_sub;
	logic [rs_pkg::ZW-1:0] z;
	logic                  acc;

	assign z   = rs_pkg::ZW'(in_data.density) * rs_pkg::ZW'(in_data.interval_time);
	assign acc = in_valid && in_ready;
	assign in_ready  = (state_q == rs_pkg::FE_IDLE);
	assign cmd_valid = (state_q == rs_pkg::FE_SEND);
	assign cmd       = cmd_q;
	assign rem_sh  = {rem_q[32:0], num_q[47]};
	assign rem_sub = {1'b0, rem_sh} - {2'b0, den_q};

	// control state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rs_pkg::FE_IDLE: begin
				if (acc) begin
					if (in_data.operation == rs_pkg::OP_SAMPLE && seen_q != '0)
						state_d = rs_pkg::FE_DIV;
					else
						state_d = rs_pkg::FE_SEND;
				end
			end
			rs_pkg::FE_DIV:  if (cnt_q == 6'd47) state_d = rs_pkg::FE_WAIT;
			rs_pkg::FE_WAIT: state_d = rs_pkg::FE_SEND;
			rs_pkg::FE_SEND: if (cmd_ready) state_d = rs_pkg::FE_IDLE;
			default:         state_d = rs_pkg::FE_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= rs_pkg::FE_IDLE;
			prev_z_q <= '0;
			seen_q   <= '0;
		end else begin
			state_q <= state_d;
			if (acc && in_data.operation == rs_pkg::OP_SAMPLE) begin
				prev_z_q <= z;
				if (in_data.last_sample)
					seen_q <= '0;
				else if (seen_q != SW'(MAX_TRACE - 1))
					seen_q <= seen_q + 1'b1;
			end
		end
	end

	// command build and division datapath
	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_q.is_tap    <= (in_data.operation == rs_pkg::OP_TAP);
			cmd_q.tap_index <= in_data.tap_index;
			cmd_q.tap_value <= in_data.tap_value;
			cmd_q.start     <= (seen_q == '0);
			cmd_q.push      <= (seen_q != '0);
			cmd_q.refl      <= '0;
			cmd_q.last      <= in_data.last_sample;
			cmd_q.taps      <= tap_count;
			num_q <= (z >= prev_z_q) ? {1'b0, z - prev_z_q, 15'b0}
			                         : {1'b0, prev_z_q - z, 15'b0};
			den_q <= {1'b0, prev_z_q} + {1'b0, z};
			neg_q <= (z < prev_z_q);
			rem_q <= '0;
			quo_q <= '0;
			cnt_q <= '0;
		end else if (state_q == rs_pkg::FE_DIV) begin
			num_q <= {num_q[46:0], 1'b0};
			cnt_q <= cnt_q + 1'b1;
			if (!rem_sub[34]) begin
				rem_q <= rem_sub[33:0];
				quo_q <= {quo_q[46:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[46:0], 1'b0};
			end
		end else if (state_q == rs_pkg::FE_WAIT) begin
			// a fall to zero impedance gives a quotient of 32768, i.e. -1.0
			if (den_q == '0)
				cmd_q.refl <= '0;
			else if (neg_q)
				cmd_q.refl <= -$signed(quo_q[15:0]);
			else if (quo_q > 48'd32767)
				cmd_q.refl <= 16'sd32767;
			else
				cmd_q.refl <= $signed({1'b0, quo_q[14:0]});
		end
	end
endmodule

// File: hw/rtl/rs_fifo.sv
module rs_fifo (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_valid,
	output logic         wr_ready,
	input  rs_pkg::cmd_t wr_data,
	output logic         rd_valid,
	input  logic         rd_ready,
	output rs_pkg::cmd_t rd_data
);
	rs_pkg::cmd_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = mem_q[rp_q];

	// two-entry command queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr_valid && wr_ready) wp_q <= ~wp_q;
			if (rd_valid && rd_ready) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'((wr_valid && wr_ready) ? 1 : 0)
			               - 2'((rd_valid && rd_ready) ? 1 : 0);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_valid && wr_ready) mem_q[wp_q] <= wr_data;
	end
endmodule

// File: hw/rtl/rs_back.sv
module rs_back #(
	parameter int MAX_TAPS  = rs_pkg::MaxTaps,
	parameter int MAX_TRACE = rs_pkg::MaxTrace
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cmd_valid,
	output logic         cmd_ready,
	input  rs_pkg::cmd_t cmd,
	output logic         out_valid,
	input  logic         out_ready,
	output rs_pkg::out_item_t out_data
);
	localparam int TW = $clog2(MAX_TAPS);
	localparam int CW = TW + 1;
	localparam int PW = $clog2(MAX_TRACE);
	localparam int WD = 1 << TW;

	rs_pkg::be_state_t state_q, state_d;
	logic signed [rs_pkg::RefW-1:0] win_mem [WD];
	logic signed [rs_pkg::TapW-1:0] taps_q [MAX_TAPS];
	logic signed [rs_pkg::TapW-1:0] tap_rd_s1;
	logic signed [rs_pkg::RefW-1:0] win_rd_s1;
	logic                           mac_v_s1;
	logic signed [31:0]             prod_s2;
	logic                           mac_v_s2;
	logic signed [rs_pkg::AccW-1:0] acc_q;
	logic [CW-1:0] used_q, centre_q, j_q, flush_q;
	logic [8:0]    fill_q;
	logic [PW-1:0] pos_q;
	logic [TW-1:0] wp_q;
	logic [TW-1:0] rd_idx;
	logic          last_q, flushing_q, tail_q;
	logic signed [rs_pkg::RefW-1:0] refl_q;
	logic signed [rs_pkg::RefW-1:0] new_r;
	logic          will_emit, mac_done;
	rs_pkg::out_item_t res_q;
	logic          res_v_q;
	logic [CW-1:0] tc_clamp;

	assign cmd_ready = (state_q == rs_pkg::BE_IDLE);
	assign out_valid = res_v_q;
	assign out_data  = res_q;
	assign mac_done  = (j_q == used_q) && !mac_v_s1 && !mac_v_s2;
	// window entry j sits j places behind the newest write
	assign rd_idx    = wp_q - TW'(1) - j_q[TW-1:0];

	always_comb begin
		if (cmd.taps == '0) tc_clamp = CW'(1);
		else if (cmd.taps > rs_pkg::TcW'(MAX_TAPS)) tc_clamp = CW'(MAX_TAPS);
		else tc_clamp = CW'(cmd.taps);
	end

	// sequencer: shift window, multiply-accumulate over taps, emit, flush zeros after the last sample
	always_comb begin
		state_d   = state_q;
		new_r     = '0;
		will_emit = (fill_q >= 9'(centre_q));
		case (state_q)
			rs_pkg::BE_IDLE: begin
				if (cmd_valid && !cmd.is_tap) begin
					if (cmd.push) state_d = rs_pkg::BE_SHIFT;
					else if (cmd.last) state_d = rs_pkg::BE_FLUSH;
				end
			end
			rs_pkg::BE_SHIFT: begin
				new_r   = flushing_q ? '0 : refl_q;
				state_d = will_emit ? rs_pkg::BE_MAC
				        : (flushing_q || last_q) ? rs_pkg::BE_FLUSH : rs_pkg::BE_IDLE;
			end
			rs_pkg::BE_MAC:  if (mac_done) state_d = rs_pkg::BE_EMIT;
			rs_pkg::BE_EMIT: begin
				if (!res_v_q || out_ready) begin
					if (tail_q) state_d = rs_pkg::BE_IDLE;
					else if (flushing_q || last_q) state_d = rs_pkg::BE_FLUSH;
					else state_d = rs_pkg::BE_IDLE;
				end
			end
			rs_pkg::BE_FLUSH: state_d = rs_pkg::BE_SHIFT;
			default: state_d = rs_pkg::BE_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= rs_pkg::BE_IDLE;
			used_q     <= CW'(MAX_TAPS);
			centre_q   <= CW'(MAX_TAPS / 2);
			fill_q     <= '0;
			pos_q      <= '0;
			wp_q       <= '0;
			refl_q     <= '0;
			last_q     <= 1'b0;
			flushing_q <= 1'b0;
			tail_q     <= 1'b0;
			flush_q    <= '0;
			res_v_q    <= 1'b0;
			mac_v_s1   <= 1'b0;
			mac_v_s2   <= 1'b0;
			j_q        <= '0;
		end else begin
			state_q <= state_d;
			if (res_v_q && out_ready) res_v_q <= 1'b0;
			mac_v_s1 <= 1'b0;
			mac_v_s2 <= mac_v_s1;
			case (state_q)
				rs_pkg::BE_IDLE: begin
					if (cmd_valid && !cmd.is_tap) begin
						last_q     <= cmd.last;
						flushing_q <= 1'b0;
						tail_q     <= 1'b0;
						flush_q    <= '0;
						if (cmd.start) begin
							used_q   <= tc_clamp;
							centre_q <= tc_clamp >> 1;
							fill_q   <= '0;
							pos_q    <= '0;
						end else begin
							refl_q <= cmd.refl;
						end
					end
				end
				rs_pkg::BE_SHIFT: begin
					wp_q <= wp_q + 1'b1;
					if (fill_q != 9'd255) fill_q <= fill_q + 1'b1;
					j_q <= '0;
					if (flushing_q) tail_q <= (flush_q == centre_q);
				end
				rs_pkg::BE_MAC: begin
					if (j_q != used_q) begin
						j_q      <= j_q + 1'b1;
						mac_v_s1 <= 1'b1;
					end
				end
				rs_pkg::BE_EMIT: begin
					if (!res_v_q || out_ready) begin
						res_v_q <= 1'b1;
						pos_q   <= (pos_q == PW'(MAX_TRACE - 1)) ? '0 : pos_q + 1'b1;
						if (tail_q) begin
							fill_q <= '0;
							pos_q  <= '0;
						end
					end
				end
				rs_pkg::BE_FLUSH: begin
					if (!flushing_q) begin
						flushing_q <= 1'b1;
						flush_q    <= '0;
					end else begin
						flush_q <= flush_q + 1'b1;
					end
				end
				default: ;
			endcase
			if (state_q == rs_pkg::BE_SHIFT && !will_emit && flushing_q
			    && flush_q == centre_q) begin
				fill_q <= '0;
				pos_q  <= '0;
			end
		end
	end

	// tap memory, reflectivity ring and multiply pipeline
	always_ff @(posedge clk) begin
		if (state_q == rs_pkg::BE_IDLE && cmd_valid && cmd.is_tap
		    && 7'(cmd.tap_index) < 7'(MAX_TAPS))
			taps_q[cmd.tap_index[TW-1:0]] <= cmd.tap_value;
		if (state_q == rs_pkg::BE_SHIFT)
			win_mem[wp_q] <= new_r;
		tap_rd_s1 <= taps_q[j_q[TW-1:0]];
		// entries not yet pushed in this trace read as zero
		win_rd_s1 <= (9'(j_q) < fill_q) ? win_mem[rd_idx] : '0;
		prod_s2   <= tap_rd_s1 * win_rd_s1;
		if (state_q == rs_pkg::BE_SHIFT)
			acc_q <= '0;
		else if (mac_v_s2)
			acc_q <= acc_q + rs_pkg::AccW'(prod_s2);
		if (state_q == rs_pkg::BE_EMIT && (!res_v_q || out_ready)) begin
			res_q.trace_value    <= acc_q[rs_pkg::ValW-1:0];
			res_q.trace_position <= rs_pkg::PosW'(pos_q);
			res_q.last_output    <= tail_q;
		end
	end
endmodule

// File: dv/reflectivity_seismogram_test.sv
module reflectivity_seismogram_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WatchLimit = 20000;
	localparam int SettleCycles = 400;

	logic clk;
	logic arst_n;

	rs_in_if  in_ch ();
	rs_out_if out_ch ();
	rs_cfg_if cfg_ch ();

	reflectivity_seismogram dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	// seismogram predictor state
	logic [31:0]        prev_imp;
	logic signed [15:0] refl_win [rs_pkg::MaxTaps];
	logic signed [15:0] wavelet [rs_pkg::MaxTaps];
	int unsigned        depth_count;
	int unsigned        out_count;
	int unsigned        tap_count_reg;
	int unsigned        taps_in_use;
	int unsigned        centre_ofs;
	int unsigned        fill_level;

	rs_pkg::out_item_t expected_trace [$];

	int  errors;
	int  items_sent;
	int  results_seen;
	int  cfg_writes;
	bit  quiet;
	int  hold_cycles;
	int  stall_cycles;

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// reflection coefficient in q1.15
	function automatic logic signed [15:0] refl_coef(logic [31:0] zc, logic [31:0] zn);
		longint unsigned sum;
		longint unsigned q;
		sum = longint'(zc) + longint'(zn);
		if (sum == 0) return '0;
		if (zn >= zc) begin
			q = (longint'(zn - zc) << 15) / sum;
			if (q > 32767) q = 32767;
			return q[15:0];
		end
		q = (longint'(zc - zn) << 15) / sum;
		return -$signed(q[15:0]);
	endfunction

	// shift one coefficient in and convolve once the centre is reached
	function automatic void push_refl(logic signed [15:0] r, bit last);
		int unsigned t;
		longint acc;
		rs_pkg::out_item_t res;
		t = fill_level;
		acc = 0;
		for (int i = rs_pkg::MaxTaps - 1; i > 0; i--) refl_win[i] = refl_win[i-1];
		refl_win[0] = r;
		if (fill_level < 255) fill_level++;
		if (t < centre_ofs) return;
		for (int j = 0; j < taps_in_use; j++)
			acc += longint'(wavelet[j]) * longint'(refl_win[j]);
		res.trace_value = acc[rs_pkg::ValW-1:0];
		res.trace_position = out_count[rs_pkg::PosW-1:0];
		res.last_output = last;
		expected_trace.push_back(res);
		out_count = (out_count + 1) % rs_pkg::MaxTrace;
	endfunction

	function automatic void predict_item(rs_pkg::in_item_t it);
		logic [31:0] z;
		if (it.operation == rs_pkg::OP_TAP) begin
			wavelet[it.tap_index] = it.tap_value;
			return;
		end
		z = {16'b0, it.density} * {16'b0, it.interval_time};
		if (depth_count == 0) begin
			taps_in_use = (tap_count_reg < 1) ? 1 :
				(tap_count_reg > rs_pkg::MaxTaps) ? rs_pkg::MaxTaps : tap_count_reg;
			centre_ofs = taps_in_use / 2;
			foreach (refl_win[i]) refl_win[i] = '0;
			fill_level = 0;
			out_count = 0;
		end else begin
			push_refl(refl_coef(prev_imp, z), 1'b0);
		end
		prev_imp = z;
		if (it.last_sample) begin
			for (int k = 0; k <= centre_ofs; k++) push_refl('0, k == centre_ofs);
			depth_count = 0;
			fill_level = 0;
			out_count = 0;
		end else if (depth_count < rs_pkg::MaxTrace - 1) begin
			depth_count++;
		end
	endfunction

	// send one input transaction
	task automatic send_item(rs_pkg::in_item_t it);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= it;
		do @(posedge clk); while (!in_ch.ready);
		predict_item(it);
		items_sent++;
	endtask

	function automatic rs_pkg::in_item_t rand_item();
		rs_pkg::in_item_t it;
		it.operation = 1'($urandom_range(0, 1));
		it.tap_index = 6'($urandom_range(0, 63));
		it.tap_value = 16'($urandom_range(0, 65535));
		it.density = 16'($urandom_range(0, 65535));
		it.interval_time = 16'($urandom_range(0, 65535));
		it.last_sample = 1'($urandom_range(0, 1));
		return it;
	endfunction

	task automatic send_tap(int idx, int val);
		rs_pkg::in_item_t it;
		it = rand_item();
		it.operation = rs_pkg::OP_TAP;
		it.tap_index = 6'(idx);
		it.tap_value = 16'(val);
		send_item(it);
	endtask

	task automatic send_sample(int dens, int itime, bit last);
		rs_pkg::in_item_t it;
		it = rand_item();
		it.operation = rs_pkg::OP_SAMPLE;
		it.density = 16'(dens);
		it.interval_time = 16'(itime);
		it.last_sample = last;
		send_item(it);
	endtask

	// random sample values, often small or zero so ties and zero sums occur
	function automatic int rand_log();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return $urandom_range(0, 15);
			2: return 65535;
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	task automatic send_trace(int len, bit mix_taps);
		for (int i = 0; i < len; i++) begin
			if (mix_taps && $urandom_range(0, 9) == 0)
				send_tap($urandom_range(0, 63), $urandom_range(0, 65535));
			send_sample(rand_log(), rand_log(), i == len - 1);
		end
	endtask

	// wait until drained, then write tap_count
	task automatic write_tap_count(int val);
		if (in_ch.valid) in_ch.valid <= 1'b0;
		wait (expected_trace.size() == 0);
		repeat (SettleCycles) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= 7'(val);
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		tap_count_reg = val;
		cfg_writes++;
	endtask

	task automatic test_load_wavelet();
		send_tap(0, 16'h7fff);
		send_tap(1, 16'h8000);
		for (int i = 2; i < rs_pkg::MaxTaps; i++) send_tap(i, $urandom_range(0, 65535));
	endtask

	task automatic test_special_traces();
		write_tap_count(64);
		// single sample trace
		send_sample(1234, 5678, 1'b1);
		// zero sum, saturation from zero, steep drop, extremes
		send_sample(0, 0, 1'b0);
		send_sample(0, 65535, 1'b0);
		send_sample(65535, 65535, 1'b0);
		send_sample(1, 1, 1'b0);
		send_sample(65535, 65535, 1'b0);
		send_sample(65535, 65535, 1'b0);
		send_sample(0, 0, 1'b1);
		// a tap load in the middle of a trace
		send_sample(300, 400, 1'b0);
		send_tap(5, 16'h8000);
		send_sample(100, 900, 1'b0);
		send_sample(7, 3, 1'b1);
	endtask

	task automatic test_tap_counts();
		int counts [7] = '{0, 1, 2, 127, 3, 33, 64};
		foreach (counts[c]) begin
			write_tap_count(counts[c]);
			send_trace(1, 1'b0);
			send_trace($urandom_range(2, 6), 1'b0);
			send_trace($urandom_range(8, 20), 1'b1);
		end
	endtask

	task automatic test_random_traces();
		int start;
		start = items_sent;
		while (items_sent - start < 180) begin
			if ($urandom_range(0, 4) == 0) write_tap_count($urandom_range(0, 127));
			quiet = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 9))
				0: send_tap($urandom_range(0, 63), $urandom_range(0, 65535));
				1: send_trace($urandom_range(20, 45), 1'b1);
				default: send_trace($urandom_range(1, 12), 1'b1);
			endcase
			quiet = 1'b0;
		end
	endtask

	// receiver stops for a long time while samples keep coming
	task automatic test_backpressure();
		write_tap_count(4);
		hold_cycles = 2500;
		send_trace(30, 1'b0);
	endtask

	// result receiver with random stalls
	initial begin
		int gap;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_cycles > 0) begin
				out_ch.ready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end
			gap = quiet ? 0 : $urandom_range(0, 14);
			if (gap > 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
		end
	end

	// compare each result transaction with the oldest prediction
	always @(posedge clk) begin
		rs_pkg::out_item_t exp_r;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			results_seen++;
			if (expected_trace.size() == 0) begin
				$display("%0t: unexpected result: got %p", $time, out_ch.data);
				errors++;
			end else begin
				exp_r = expected_trace.pop_front();
				if (out_ch.data.trace_value !== exp_r.trace_value) begin
					$display("%0t: trace_value expected %0d actual %0d", $time,
						exp_r.trace_value, out_ch.data.trace_value);
					errors++;
				end
				if (out_ch.data.trace_position !== exp_r.trace_position) begin
					$display("%0t: trace_position expected %0d actual %0d", $time,
						exp_r.trace_position, out_ch.data.trace_position);
					errors++;
				end
				if (out_ch.data.last_output !== exp_r.last_output) begin
					$display("%0t: last_output expected %0b actual %0b", $time,
						exp_r.last_output, out_ch.data.last_output);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WatchLimit) begin
			$display("%0t: watchdog, %0d results still expected", $time,
				expected_trace.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		errors = 0;
		items_sent = 0;
		results_seen = 0;
		cfg_writes = 0;
		quiet = 1'b0;
		hold_cycles = 0;
		stall_cycles = 0;
		prev_imp = '0;
		foreach (refl_win[i]) refl_win[i] = '0;
		foreach (wavelet[i]) wavelet[i] = '0;
		depth_count = 0;
		out_count = 0;
		tap_count_reg = 64;
		taps_in_use = rs_pkg::MaxTaps;
		centre_ofs = rs_pkg::MaxTaps / 2;
		fill_level = 0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_load_wavelet();
		test_special_traces();
		test_tap_counts();
		test_backpressure();
		test_random_traces();

		in_ch.valid <= 1'b0;
		wait (expected_trace.size() == 0);
		repeat (SettleCycles) @(posedge clk);
		$display("sent %0d items, checked %0d results, %0d tap_count writes",
			items_sent, results_seen, cfg_writes);
		$display("covered tap counts 0 to 127, single and long traces, mid-trace tap loads, long stall");
		if (errors == 0 && expected_trace.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// File: reflectivity_seismogram.f
hw/rtl/rs_pkg.sv
hw/rtl/rs_if.sv
hw/rtl/rs_front.sv
hw/rtl/rs_fifo.sv
hw/rtl/rs_back.sv
hw/rtl/reflectivity_seismogram.sv
dv/reflectivity_seismogram_test.sv
